// File: rtl/roai_pkg.sv
// ============================================================================
// roai_pkg - shared types and constants for the relay output arbiter
// Request and result layouts, configuration record, opcodes, register
// indexes and frame decode constants.
// ============================================================================
package roai_pkg;

    localparam int RELAY_W      = 8;
    localparam int CHANNELS_DEF = 8;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int AGE_W        = 32;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ECU    = 2'd1,
        OP_DASH   = 2'd2,
        OP_SAFETY = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRESH_TIMEOUT = 3'd0,
        CFG_RELEASE_DELAY = 3'd1,
        CFG_CONTROL_DIV   = 3'd2,
        CFG_APPLY_DIV     = 3'd3,
        CFG_INTERLOCK     = 3'd4,
        CFG_DEBUG_LIFE    = 3'd5
    } cfg_idx_t;

    // Winning control source
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_ECU  = 2'd1,
        SRC_DASH = 2'd2
    } src_t;

    // Frame decode
    localparam logic [7:0] DASH_MAGIC     = 8'hA5;
    localparam logic [7:0] DASH_OP_OUTPUT = 8'h01;
    localparam logic [3:0] DASH_MIN_LEN   = 4'd5;
    localparam logic [3:0] ECU_ALT_MIN_LEN = 4'd2;
    localparam int FLAG_ARMED_BIT = 0;
    localparam int FLAG_START_BIT = 1;
    localparam int FLAG_DEBUG_BIT = 2;

    // Status flag bit positions
    localparam int CF_DEBUG      = 0;
    localparam int CF_ECU_FRESH  = 1;
    localparam int CF_DASH_FRESH = 2;
    localparam int CF_ARMED      = 3;
    localparam int CF_OVERRIDE   = 4;
    localparam int CF_BLOCKED    = 5;
    localparam int CF_START      = 7;

    // Configuration reset values
    localparam logic [15:0] FRESH_TIMEOUT_RST = 16'd500;
    localparam logic [15:0] RELEASE_DELAY_RST = 16'd500;
    localparam logic [7:0]  CONTROL_DIV_RST   = 8'd10;
    localparam logic [7:0]  APPLY_DIV_RST     = 8'd50;
    localparam logic [7:0]  INTERLOCK_RST     = 8'h19;
    localparam logic [3:0]  DEBUG_LIFE_RST    = 4'd10;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] frame_length;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic [3:0] safety_sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] relay_drive;
        logic       start_drive;
        logic [7:0] requested_mask;
        logic [7:0] applied_mask;
        logic [7:0] control_flags;
        logic [3:0] fault_bits;
    } result_t;

    typedef struct packed {
        logic [15:0] fresh_timeout_ms;
        logic [15:0] release_delay_ms;
        logic [7:0]  control_divider;
        logic [7:0]  apply_divider;
        logic [7:0]  interlock_mask;
        logic [3:0]  debug_lifetime;
    } cfg_t;

    // Mask with one bit set for each implemented relay channel
    function automatic logic [RELAY_W-1:0] chan_mask(input int channels);
        logic [RELAY_W-1:0] m;
        for (int i = 0; i < RELAY_W; i++)
        begin
            m[i] = (i < channels);
        end
        return m;
    endfunction

endpackage

// File: rtl/roai_if.sv
// ============================================================================
// roai_if - request and result channel interfaces
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ============================================================================
interface roai_in_if;
    import roai_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface roai_out_if;
    import roai_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/roai_cfg_regs.sv
// ============================================================================
// roai_cfg_regs - configuration register file
// Write-only registers loaded from the plain write port.
// ============================================================================
module roai_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [roai_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [roai_pkg::CFG_W-1:0]     cfg_wdata,
    output roai_pkg::cfg_t                 cfg
);
    import roai_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRESH_TIMEOUT: cfg_next.fresh_timeout_ms = cfg_wdata;
                CFG_RELEASE_DELAY: cfg_next.release_delay_ms = cfg_wdata;
                CFG_CONTROL_DIV:   cfg_next.control_divider  = cfg_wdata[7:0];
                CFG_APPLY_DIV:     cfg_next.apply_divider    = cfg_wdata[7:0];
                CFG_INTERLOCK:     cfg_next.interlock_mask   = cfg_wdata[7:0];
                CFG_DEBUG_LIFE:    cfg_next.debug_lifetime   = cfg_wdata[3:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fresh_timeout_ms <= FRESH_TIMEOUT_RST;
            cfg_reg.release_delay_ms <= RELEASE_DELAY_RST;
            cfg_reg.control_divider  <= CONTROL_DIV_RST;
            cfg_reg.apply_divider    <= APPLY_DIV_RST;
            cfg_reg.interlock_mask   <= INTERLOCK_RST;
            cfg_reg.debug_lifetime   <= DEBUG_LIFE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/roai_in_stage.sv
// ============================================================================
// roai_in_stage - request input register
// Captures one request and holds it until the engine consumes it.
// ============================================================================
module roai_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    roai_in_if.sink             item,
    input  logic                advance,
    output logic                hold_valid,
    output roai_pkg::in_item_t  hold_item
);
    import roai_pkg::*;

    logic     hold_valid_reg;
    logic     hold_valid_next;
    in_item_t hold_item_reg;
    logic     take;

    // Accept a new request when empty or when the held one moves on
    assign item.ready = rst_n && (!hold_valid_reg || advance);
    assign take       = item.valid && item.ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_item_reg <= item.payload;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_item  = hold_item_reg;

endmodule

// File: rtl/roai_engine.sv
// ============================================================================
// roai_engine - controller state and single-pass update
// Holds the arbiter, interlock and divider state and computes the next
// state and the result for one request combinationally.
// ============================================================================
module roai_engine #(
    parameter int CHANNELS = roai_pkg::CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  roai_pkg::in_item_t req,
    input  roai_pkg::cfg_t     cfg,
    output roai_pkg::result_t  result_next
);
    import roai_pkg::*;

    // Source stamps are kept as ages since the stamp
    typedef struct packed {
        logic [AGE_W-1:0] ecu_age;
        logic [AGE_W-1:0] dash_age;
        logic [AGE_W-1:0] release_age;
        logic [7:0]       ecu_frame_mask;
        logic [7:0]       dash_frame_mask;
        logic             ecu_valid;
        logic             dash_valid;
        logic             dash_armed;
        logic             dash_start;
        logic [3:0]       safety_latched;
        logic             safety_changed;
        logic             inhibit_active;
        logic             release_waiting;
        logic             refresh_waiting;
        logic [7:0]       control_count;
        logic [7:0]       apply_count;
        logic             start_level;
        logic [7:0]       resolved_mask;
        logic [7:0]       granted_mask;
        src_t             source_select;
        logic             desired_start;
        logic [3:0]       debug_count;
    } state_t;

    typedef struct packed {
        src_t       src;
        logic [7:0] mask;
        logic       start;
    } resolve_t;

    localparam state_t STATE_RST = '{
        ecu_age:         '0,
        dash_age:        '0,
        release_age:     '0,
        ecu_frame_mask:  '0,
        dash_frame_mask: '0,
        ecu_valid:       1'b0,
        dash_valid:      1'b0,
        dash_armed:      1'b0,
        dash_start:      1'b1,
        safety_latched:  '0,
        safety_changed:  1'b0,
        inhibit_active:  1'b0,
        release_waiting: 1'b0,
        refresh_waiting: 1'b0,
        control_count:   '0,
        apply_count:     '0,
        start_level:     1'b1,
        resolved_mask:   '0,
        granted_mask:    '0,
        source_select:   SRC_NONE,
        desired_start:   1'b1,
        debug_count:     '0
    };

    state_t              state_reg;
    state_t              state_next;
    logic [CHANNELS-1:0] relay_reg;
    logic [CHANNELS-1:0] relay_next;

    function automatic logic is_fresh(input logic valid, input logic [AGE_W-1:0] age,
                                      input logic [15:0] limit);
        return valid && (age <= AGE_W'(limit));
    endfunction

    // Armed fresh override first, then fresh ECU mask, else all off
    function automatic resolve_t resolve(input state_t st, input logic [15:0] limit);
        resolve_t r;
        priority if (st.dash_armed && is_fresh(st.dash_valid, st.dash_age, limit))
        begin
            r = '{src: SRC_DASH, mask: st.dash_frame_mask, start: st.dash_start};
        end
        else if (is_fresh(st.ecu_valid, st.ecu_age, limit))
        begin
            r = '{src: SRC_ECU, mask: st.ecu_frame_mask, start: 1'b1};
        end
        else
        begin
            r = '{src: SRC_NONE, mask: 8'd0, start: 1'b1};
        end
        return r;
    endfunction

    always_comb
    begin
        state_t              s;
        logic [CHANNELS-1:0] relay;
        logic [CHANNELS-1:0] lock;
        logic [7:0]          ctrl_cnt;
        logic [7:0]          apply_cnt;
        logic                run_ctrl;
        logic                run_apply;
        logic                active;
        logic                blocked;
        logic [7:0]          ecu_dec;
        logic [7:0]          grant;
        resolve_t            res;
        logic [7:0]          flags;

        s         = state_reg;
        relay     = relay_reg;
        lock      = cfg.interlock_mask[CHANNELS-1:0];
        ctrl_cnt  = '0;
        apply_cnt = '0;
        run_ctrl  = 1'b0;
        run_apply = 1'b0;
        active    = (state_reg.safety_latched != 4'd0);
        blocked   = 1'b0;
        ecu_dec   = '0;
        grant     = '0;
        res       = '{src: SRC_NONE, mask: 8'd0, start: 1'b1};

        unique case (op_t'(req.opcode))
            OP_TICK:
            begin
                // Age the sources and step the dividers
                s.ecu_age     = s.ecu_age + AGE_W'(1);
                s.dash_age    = s.dash_age + AGE_W'(1);
                s.release_age = s.release_age + AGE_W'(1);
                ctrl_cnt      = s.control_count + 8'd1;
                run_ctrl      = (ctrl_cnt >= cfg.control_divider);
                s.control_count = run_ctrl ? 8'd0 : ctrl_cnt;
                apply_cnt     = s.apply_count + 8'd1;
                run_apply     = (apply_cnt >= cfg.apply_divider);
                s.apply_count = run_apply ? 8'd0 : apply_cnt;
                res           = resolve(s, cfg.fresh_timeout_ms);

                // Control service: interlock entry, release timing, refresh
                if (run_ctrl)
                begin
                    if (s.safety_changed)
                    begin
                        s.safety_changed = 1'b0;
                        if (active)
                        begin
                            relay             = relay & ~lock;
                            s.inhibit_active  = 1'b1;
                            s.release_waiting = 1'b0;
                        end
                        else if (s.inhibit_active)
                        begin
                            s.inhibit_active  = 1'b0;
                            s.release_waiting = 1'b1;
                            s.release_age     = '0;
                        end
                    end
                    if (s.release_waiting)
                    begin
                        if (active)
                        begin
                            s.release_waiting = 1'b0;
                            s.inhibit_active  = 1'b1;
                        end
                        else if (s.release_age >= AGE_W'(cfg.release_delay_ms))
                        begin
                            s.release_waiting = 1'b0;
                            s.refresh_waiting = 1'b1;
                        end
                    end
                    if (s.refresh_waiting && !(s.inhibit_active || s.release_waiting))
                    begin
                        s.refresh_waiting = 1'b0;
                        s.source_select   = res.src;
                        s.resolved_mask   = res.mask;
                        s.desired_start   = res.start;
                        relay = (relay & ~lock) | (res.mask[CHANNELS-1:0] & lock);
                    end
                end

                // Resolve and apply, then age the debug lifetime
                if (run_apply)
                begin
                    blocked         = s.inhibit_active || s.release_waiting;
                    s.source_select = res.src;
                    s.resolved_mask = res.mask;
                    s.desired_start = res.start;
                    grant           = blocked ? (res.mask & ~cfg.interlock_mask) : res.mask;
                    s.granted_mask  = grant;
                    relay           = grant[CHANNELS-1:0];
                    s.start_level   = res.start;
                    if (s.debug_count != 4'd0)
                    begin
                        s.debug_count = s.debug_count - 4'd1;
                    end
                end
            end

            OP_ECU:
            begin
                // Decode the mask and drive the relays at once
                priority if (req.frame_length == 4'd0)
                begin
                    ecu_dec = 8'd0;
                end
                else if (req.frame_length >= ECU_ALT_MIN_LEN && req.byte_zero == 8'd0 &&
                         req.byte_one != 8'd0)
                begin
                    ecu_dec = req.byte_one;
                end
                else
                begin
                    ecu_dec = req.byte_zero;
                end
                s.ecu_frame_mask = ecu_dec;
                s.ecu_age        = '0;
                s.ecu_valid      = 1'b1;
                blocked          = s.inhibit_active || s.release_waiting;
                grant            = blocked ? (ecu_dec & ~cfg.interlock_mask) : ecu_dec;
                s.granted_mask   = grant;
                relay            = grant[CHANNELS-1:0];
                s.start_level    = 1'b1;
                s.dash_armed     = 1'b0;
            end

            OP_DASH:
            begin
                // Drop frames that are short or lack the magic byte
                if (req.frame_length >= DASH_MIN_LEN && req.byte_four == DASH_MAGIC)
                begin
                    if (req.byte_zero == DASH_OP_OUTPUT)
                    begin
                        s.dash_frame_mask = req.byte_one;
                        s.dash_armed      = req.byte_three[FLAG_ARMED_BIT];
                        s.dash_start      = req.byte_three[FLAG_START_BIT];
                        s.dash_age        = '0;
                        s.dash_valid      = 1'b1;
                    end
                    if (req.byte_three[FLAG_DEBUG_BIT])
                    begin
                        s.debug_count = cfg.debug_lifetime;
                    end
                end
            end

            OP_SAFETY:
            begin
                // Latch a changed sample; a live fault drops the locked channels
                if (req.safety_sample != s.safety_latched)
                begin
                    s.safety_latched = req.safety_sample;
                    s.safety_changed = 1'b1;
                    if (req.safety_sample != 4'd0)
                    begin
                        relay             = relay & ~lock;
                        s.refresh_waiting = 1'b1;
                    end
                end
            end

            default:
            begin
                s = state_reg;
            end
        endcase

        state_next = s;
        relay_next = relay;

        // Build the status flags from the updated state
        flags                = '0;
        flags[CF_DEBUG]      = (s.debug_count != 4'd0);
        flags[CF_ECU_FRESH]  = is_fresh(s.ecu_valid, s.ecu_age, cfg.fresh_timeout_ms);
        flags[CF_DASH_FRESH] = is_fresh(s.dash_valid, s.dash_age, cfg.fresh_timeout_ms);
        flags[CF_ARMED]      = s.dash_armed;
        flags[CF_OVERRIDE]   = (s.source_select == SRC_DASH);
        flags[CF_BLOCKED]    = s.inhibit_active || s.release_waiting;
        flags[CF_START]      = s.desired_start;

        result_next.relay_drive    = RELAY_W'(relay);
        result_next.start_drive    = s.start_level;
        result_next.requested_mask = s.resolved_mask;
        result_next.applied_mask   = s.granted_mask;
        result_next.control_flags  = flags;
        result_next.fault_bits     = s.safety_latched;
    end

    // Commit state when the request is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RST;
            relay_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            relay_reg <= relay_next;
        end
    end

endmodule

// File: rtl/roai_out_stage.sv
// ============================================================================
// roai_out_stage - result register
// Holds one result until the sink takes it; frees in the same cycle.
// ============================================================================
module roai_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    input  roai_pkg::result_t data,
    output logic              advance,
    roai_out_if.source        result
);
    import roai_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Move on when empty or when the current result is taken
    assign advance    = !valid_reg || result.ready;
    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            data_reg <= data;
        end
    end

    assign result.valid   = valid_reg;
    assign result.payload = data_reg;

endmodule

// File: rtl/relay_output_arbiter_interlock_core.sv
// ============================================================================
// relay_output_arbiter_interlock_core - relay output controller top level
// Arbitrates ECU and dashboard masks, applies the safety interlock and
// release delay, and reports relay drive and status for every request.
// ============================================================================
// Path: an accepted request waits in the input register, then passes the
//   single-pass state update into the result register.
// Throughput: one request per cycle while the result sink takes results.
// Reset: engine state and both valid flags clear asynchronously; start
//   drive and desired start come up high, configuration takes its defaults.
module relay_output_arbiter_interlock_core #(
    parameter int CHANNELS = roai_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    roai_in_if.sink                        item,
    roai_out_if.source                     result,
    input  logic                           cfg_we,
    input  logic [roai_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [roai_pkg::CFG_W-1:0]     cfg_wdata
);
    import roai_pkg::*;

    cfg_t     cfg;
    logic     hold_valid;
    in_item_t hold_item;
    logic     advance;
    logic     fire;
    result_t  result_next;

    // Consume the held request whenever the result register can take it
    assign fire = hold_valid && advance;

    roai_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    roai_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    roai_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .req         (hold_item),
        .cfg         (cfg),
        .result_next (result_next)
    );

    roai_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (hold_valid),
        .data       (result_next),
        .advance    (advance),
        .result     (result)
    );

endmodule

// File: rtl/roai_checker.sv
// ============================================================================
// roai_checker - port-level checks for the relay output controller
// Watches the request and result channels and is bound to the top level.
// ============================================================================
module roai_checker #(
    parameter int CHANNELS = roai_pkg::CHANNELS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic [1:0]        item_opcode,
    input logic              result_valid,
    input logic              result_ready,
    input roai_pkg::result_t result_payload
);
    import roai_pkg::*;

    localparam logic [RELAY_W-1:0] CHAN_MASK = chan_mask(CHANNELS);

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_payload))
        else $error("result payload changed while stalled");

    // A fresh result follows a request accepted through the input and result registers
    a_rise_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result appeared without a request");

    // An ECU frame drives the relays straight from the applied mask
    a_ecu_applies: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid) &&
        $past(item_valid && item_ready && (item_opcode == OP_ECU), 2)
        |-> result_payload.start_drive &&
            (result_payload.relay_drive == (result_payload.applied_mask & CHAN_MASK)))
        else $error("ECU frame result does not drive its applied mask");

endmodule

bind relay_output_arbiter_interlock_core roai_checker #(
    .CHANNELS (CHANNELS)
) u_roai_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_opcode    (item.payload.opcode),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);
